// ===== rtl/olist_pkg.sv =====
// Shared types and constants for the ordered list engine.
package olist_pkg;

  // Default list capacity in entries.
  localparam int unsigned DEPTH_DEF = 64;

  // Widths fixed by the transaction fields.
  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 7;
  localparam int unsigned CMD_W = 3;

  // Command codes. The eighth code is unused and changes nothing.
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_SEARCH    = 3'd6
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Kind of list modification carried out by a command.
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } op_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SHIFT = 2'd1,
    S_SCAN  = 2'd2,
    S_DONE  = 2'd3
  } state_e;

  // Input transaction.
  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    status_e                 status;
    logic [POS_W-1:0]        entry_count;
    logic signed [VAL_W-1:0] min_value;
    logic signed [VAL_W-1:0] max_value;
    logic                    found;
    logic [POS_W-1:0]        found_position;
    logic signed [VAL_W-1:0] removed_value;
  } out_item_t;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic clear;
    logic vld;
    logic srch;
  } scan_ctl_t;

endpackage

// ===== rtl/olist_scan.sv =====
// Scan unit: running minimum, maximum and first search match over streamed entries.
module olist_scan #(
  parameter int unsigned DEPTH = olist_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  olist_pkg::scan_ctl_t                ctl_i,
  input  logic [$clog2(DEPTH)-1:0]            tag_i,
  input  logic signed [olist_pkg::VAL_W-1:0]  data_i,
  input  logic signed [olist_pkg::VAL_W-1:0]  key_i,
  output logic signed [olist_pkg::VAL_W-1:0]  min_o,
  output logic signed [olist_pkg::VAL_W-1:0]  max_o,
  output logic                                found_o,
  output logic [olist_pkg::POS_W-1:0]         fpos_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned OW = $clog2(DEPTH + 1);

  logic signed [olist_pkg::VAL_W-1:0] min_q, min_d;
  logic signed [olist_pkg::VAL_W-1:0] max_q, max_d;
  logic                               found_q, found_d;
  logic [olist_pkg::POS_W-1:0]        fpos_q, fpos_d;
  logic [OW-1:0]                      pos_w;
  logic                               first;

  // The entry at the head of the list seeds the extremes.
  assign first = (tag_i == AW'(0));
  assign pos_w = OW'(tag_i) + OW'(1);

  always_comb begin
    min_d   = min_q;
    max_d   = max_q;
    found_d = found_q;
    fpos_d  = fpos_q;
    if (ctl_i.clear) begin
      found_d = 1'b0;
      fpos_d  = '0;
    end else if (ctl_i.vld) begin
      if (first || (data_i < min_q)) begin
        min_d = data_i;
      end
      if (first || (data_i > max_q)) begin
        max_d = data_i;
      end
      // Only the first match in list order counts.
      if (ctl_i.srch && !found_q && (data_i == key_i)) begin
        found_d = 1'b1;
        fpos_d  = olist_pkg::POS_W'(pos_w);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q  <= min_d;
    max_q  <= max_d;
    fpos_q <= fpos_d;
  end

  assign min_o   = min_q;
  assign max_o   = max_q;
  assign found_o = found_q;
  assign fpos_o  = fpos_q;

endmodule

// ===== rtl/ordered_list_engine.sv =====
// Ordered list engine: list storage in one synchronous RAM with a shift and scan sequencer.
// Each accepted command runs a shift phase (skipped for a command that changes nothing), then a
// scan phase over the entries, then loads the result once the output register is free.
// One transaction at a time: a new one is accepted in the cycle after the previous result is
// loaded; the single read port of the list RAM sets this.
// Reset clears the occupancy and control state; RAM contents are left as they are.
module ordered_list_engine #(
  parameter int unsigned DEPTH = olist_pkg::DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  olist_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output olist_pkg::out_item_t out_data_o
);

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned OW  = $clog2(DEPTH + 1);
  localparam int unsigned CW  = ((OW > olist_pkg::POS_W) ? OW : olist_pkg::POS_W) + 1;
  localparam int unsigned VW  = olist_pkg::VAL_W;

  // List storage.
  logic [VW-1:0] mem [DEPTH];
  logic [VW-1:0] rdata_q;

  // Sequencer state.
  olist_pkg::state_e  state_q, state_d;
  olist_pkg::op_e     op_q, op_d;
  olist_pkg::status_e status_q, status_d;
  logic [olist_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic signed [VW-1:0] val_q, val_d;
  logic [AW-1:0] k_q, k_d;
  logic [OW-1:0] rem_q, rem_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [OW-1:0] occ_q, occ_d;
  logic          rd_vld_q;
  logic [AW-1:0] tag_q;
  logic signed [VW-1:0] removed_q, removed_d;
  logic                 out_valid_q, out_valid_d;
  olist_pkg::out_item_t out_data_q, out_data_d;

  // RAM port controls.
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [VW-1:0] wdata;

  // Decode of a new transaction.
  logic          full, empty;
  logic [CW-1:0] pos_ext, occ_ext;
  logic [AW-1:0] k_pos;
  logic          ins_pos_ok, del_pos_ok;
  olist_pkg::op_e     new_op;
  olist_pkg::status_e new_status;
  logic [AW-1:0]      new_k;

  // Scan unit connection.
  olist_pkg::scan_ctl_t  scan_ctl;
  logic signed [VW-1:0]  scan_min, scan_max;
  logic                  scan_found;
  logic [olist_pkg::POS_W-1:0] scan_fpos;

  assign full       = (occ_q == OW'(DEPTH));
  assign empty      = (occ_q == '0);
  assign pos_ext    = CW'(in_data_i.position);
  assign occ_ext    = CW'(occ_q);
  assign k_pos      = AW'(pos_ext - CW'(1));
  assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= occ_ext + CW'(1));
  assign del_pos_ok = (pos_ext != '0) && (pos_ext <= occ_ext);

  // Work out the status, the kind of change and the list index of a new transaction.
  always_comb begin
    new_op     = olist_pkg::OP_NONE;
    new_status = olist_pkg::ST_OK;
    new_k      = '0;
    unique case (in_data_i.cmd)
      olist_pkg::CMD_INS_FRONT: begin
        if (full) new_status = olist_pkg::ST_FULL;
        else new_op = olist_pkg::OP_INS;
      end
      olist_pkg::CMD_INS_BACK: begin
        if (full) begin
          new_status = olist_pkg::ST_FULL;
        end else begin
          new_op = olist_pkg::OP_INS;
          new_k  = AW'(occ_q);
        end
      end
      olist_pkg::CMD_INS_POS: begin
        if (full) begin
          new_status = olist_pkg::ST_FULL;
        end else if (!ins_pos_ok) begin
          new_status = olist_pkg::ST_RANGE;
        end else begin
          new_op = olist_pkg::OP_INS;
          new_k  = k_pos;
        end
      end
      olist_pkg::CMD_DEL_FRONT: begin
        if (empty) new_status = olist_pkg::ST_EMPTY;
        else new_op = olist_pkg::OP_DEL;
      end
      olist_pkg::CMD_DEL_BACK: begin
        if (empty) begin
          new_status = olist_pkg::ST_EMPTY;
        end else begin
          new_op = olist_pkg::OP_DEL;
          new_k  = AW'(occ_q - OW'(1));
        end
      end
      olist_pkg::CMD_DEL_POS: begin
        if (empty) begin
          new_status = olist_pkg::ST_EMPTY;
        end else if (!del_pos_ok) begin
          new_status = olist_pkg::ST_RANGE;
        end else begin
          new_op = olist_pkg::OP_DEL;
          new_k  = k_pos;
        end
      end
      olist_pkg::CMD_SEARCH: begin
        if (empty) new_status = olist_pkg::ST_EMPTY;
      end
      default: begin
      end
    endcase
  end

  // Next state, RAM accesses and result loading.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    status_d    = status_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    k_d         = k_q;
    rem_d       = rem_q;
    ptr_d       = ptr_q;
    occ_d       = occ_q;
    removed_d   = removed_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_en       = 1'b0;
    rd_addr     = ptr_q;
    we          = 1'b0;
    waddr       = k_q;
    wdata       = val_q;
    scan_ctl    = '{clear: 1'b0, vld: 1'b0, srch: 1'b0};
    in_stall_o  = 1'b1;

    unique case (state_q)
      olist_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d      = new_op;
          status_d  = new_status;
          cmd_d     = in_data_i.cmd;
          val_d     = in_data_i.value;
          k_d       = new_k;
          removed_d = '0;
          if (new_op == olist_pkg::OP_NONE) begin
            // Nothing moves: go straight to the scan.
            rem_d          = occ_q;
            ptr_d          = '0;
            scan_ctl.clear = 1'b1;
            state_d        = olist_pkg::S_SCAN;
          end else begin
            rem_d   = occ_q - OW'(new_k);
            ptr_d   = (new_op == olist_pkg::OP_INS) ? AW'(occ_q - OW'(1)) : new_k;
            state_d = olist_pkg::S_SHIFT;
          end
        end
      end

      olist_pkg::S_SHIFT: begin
        // Insert reads downwards and writes one place up; delete reads upwards
        // and writes one place down, so a write never meets a pending read.
        if (rem_q != '0) begin
          rd_en = 1'b1;
          rem_d = rem_q - OW'(1);
          ptr_d = (op_q == olist_pkg::OP_INS) ? ptr_q - AW'(1) : ptr_q + AW'(1);
        end
        if (rd_vld_q) begin
          wdata = rdata_q;
          if (op_q == olist_pkg::OP_INS) begin
            we    = 1'b1;
            waddr = tag_q + AW'(1);
          end else if (tag_q == k_q) begin
            removed_d = rdata_q;
          end else begin
            we    = 1'b1;
            waddr = tag_q - AW'(1);
          end
        end else if (rem_q == '0) begin
          // All moves written: place the new entry and settle the count.
          if (op_q == olist_pkg::OP_INS) begin
            we    = 1'b1;
            occ_d = occ_q + OW'(1);
          end else begin
            occ_d = occ_q - OW'(1);
          end
          rem_d          = occ_d;
          ptr_d          = '0;
          scan_ctl.clear = 1'b1;
          state_d        = olist_pkg::S_SCAN;
        end
      end

      olist_pkg::S_SCAN: begin
        scan_ctl.vld  = rd_vld_q;
        scan_ctl.srch = (cmd_q == olist_pkg::CMD_SEARCH);
        if (rem_q != '0) begin
          rd_en = 1'b1;
          rem_d = rem_q - OW'(1);
          ptr_d = ptr_q + AW'(1);
        end else if (!rd_vld_q) begin
          state_d = olist_pkg::S_DONE;
        end
      end

      olist_pkg::S_DONE: begin
        // Load the result once the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d               = 1'b1;
          out_data_d.status         = status_q;
          out_data_d.entry_count    = olist_pkg::POS_W'(occ_q);
          out_data_d.min_value      = (occ_q == '0) ? '0 : scan_min;
          out_data_d.max_value      = (occ_q == '0) ? '0 : scan_max;
          out_data_d.found          = scan_found;
          out_data_d.found_position = scan_fpos;
          out_data_d.removed_value  = removed_q;
          state_d                   = olist_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = olist_pkg::S_IDLE;
      end
    endcase
  end

  // List RAM: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olist_pkg::S_IDLE;
      op_q        <= olist_pkg::OP_NONE;
      rem_q       <= '0;
      occ_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      rem_q       <= rem_d;
      occ_q       <= occ_d;
      rd_vld_q    <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    cmd_q      <= cmd_d;
    val_q      <= val_d;
    k_q        <= k_d;
    ptr_q      <= ptr_d;
    tag_q      <= rd_addr;
    removed_q  <= removed_d;
    out_data_q <= out_data_d;
  end

  olist_scan #(
    .DEPTH(DEPTH)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (scan_ctl),
    .tag_i  (tag_q),
    .data_i (rdata_q),
    .key_i  (val_q),
    .min_o  (scan_min),
    .max_o  (scan_max),
    .found_o(scan_found),
    .fpos_o (scan_fpos)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/olist_chk.sv =====
// Port checker for the ordered list engine, with its bind to the top level.
module olist_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input olist_pkg::in_item_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input olist_pkg::out_item_t out_data_o
);

  // A stalled result transaction stays offered unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // One transaction at a time: the input stalls right after an accept.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while busy");

  // An empty list reports no entries and zero extremes.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == olist_pkg::ST_EMPTY) |->
      (out_data_o.entry_count == '0) && (out_data_o.min_value == '0) &&
      (out_data_o.max_value == '0) && !out_data_o.found)
    else $error("empty result carries data");

  // A search hit names a position and never comes with a removal.
  a_found_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |->
      (out_data_o.found_position != '0) && (out_data_o.status == olist_pkg::ST_OK) &&
      (out_data_o.removed_value == '0) &&
      (out_data_o.min_value <= out_data_o.max_value))
    else $error("inconsistent search hit");

  // A refused command removes nothing.
  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != olist_pkg::ST_OK) |->
      (out_data_o.removed_value == '0))
    else $error("refused command removed an entry");

endmodule

bind ordered_list_engine olist_chk u_olist_chk (.*);

// ===== tb/ordered_list_engine_tb.sv =====
// Self-checking testbench for the ordered list engine: directed corner cases, then random traffic.
`timescale 1ns / 1ps

module ordered_list_engine_tb;

  localparam int unsigned DEPTH = olist_pkg::DEPTH_DEF;
  // The eighth command code has no operation behind it.
  localparam logic [olist_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int ITEMS_PER_PHASE = 530;
  // Longest command: a full shift plus a full scan, with some margin.
  localparam int SETTLE_CYCLES = 2 * DEPTH + 16;

  // Scoreboard: a shadow copy of the list that predicts each result transaction.
  class list_scoreboard;
    logic signed [olist_pkg::VAL_W-1:0] entries[$];
    olist_pkg::out_item_t pending_results[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Apply an accepted command to the shadow list and queue the result it should give.
    function void note_command(olist_pkg::in_item_t item);
      olist_pkg::out_item_t r;
      int n;
      int pos;
      bit full;
      bit empty;
      r = '0;
      n = entries.size();
      pos = int'(item.position);
      full = n >= DEPTH;
      empty = n == 0;
      r.status = olist_pkg::ST_OK;
      case (item.cmd)
        olist_pkg::CMD_INS_FRONT: begin
          if (full) r.status = olist_pkg::ST_FULL;
          else entries.push_front(item.value);
        end
        olist_pkg::CMD_INS_BACK: begin
          if (full) r.status = olist_pkg::ST_FULL;
          else entries.push_back(item.value);
        end
        olist_pkg::CMD_INS_POS: begin
          if (full) r.status = olist_pkg::ST_FULL;
          else if (pos < 1 || pos > n + 1) r.status = olist_pkg::ST_RANGE;
          else entries.insert(pos - 1, item.value);
        end
        olist_pkg::CMD_DEL_FRONT: begin
          if (empty) r.status = olist_pkg::ST_EMPTY;
          else r.removed_value = entries.pop_front();
        end
        olist_pkg::CMD_DEL_BACK: begin
          if (empty) r.status = olist_pkg::ST_EMPTY;
          else r.removed_value = entries.pop_back();
        end
        olist_pkg::CMD_DEL_POS: begin
          if (empty) begin
            r.status = olist_pkg::ST_EMPTY;
          end else if (pos < 1 || pos > n) begin
            r.status = olist_pkg::ST_RANGE;
          end else begin
            r.removed_value = entries[pos - 1];
            entries.delete(pos - 1);
          end
        end
        olist_pkg::CMD_SEARCH: begin
          if (empty) begin
            r.status = olist_pkg::ST_EMPTY;
          end else begin
            // The first match from the front wins.
            for (int i = 0; i < n; i++) begin
              if (entries[i] == item.value) begin
                r.found = 1'b1;
                r.found_position = olist_pkg::POS_W'(i + 1);
                break;
              end
            end
          end
        end
        default: begin
        end
      endcase

      // Count, minimum and maximum describe the list after the command.
      r.entry_count = olist_pkg::POS_W'(entries.size());
      if (entries.size() > 0) begin
        r.min_value = entries[0];
        r.max_value = entries[0];
        foreach (entries[i]) begin
          if (entries[i] < r.min_value) r.min_value = entries[i];
          if (entries[i] > r.max_value) r.max_value = entries[i];
        end
      end
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    // Compare an accepted result transaction with the oldest prediction.
    function void check_result(olist_pkg::out_item_t got);
      olist_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result transaction arrived with no command outstanding");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("min_value", want.min_value, got.min_value);
      compare_field("max_value", want.max_value, got.max_value);
      compare_field("found", want.found, got.found);
      compare_field("found_position", want.found_position, got.found_position);
      compare_field("removed_value", want.removed_value, got.removed_value);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  olist_pkg::in_item_t  in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  olist_pkg::out_item_t out_data_o;

  list_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit filling = 1'b1;

  ordered_list_engine #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Check every result transaction as it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Safety net against a hung block.
  initial begin
    #15_000_000;
    $display("ordered_list_engine_tb: errors");
    $finish;
  end

  // Offer one command, starting and ending at a falling edge, with random idle cycles first.
  task automatic push_command(olist_pkg::in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_command(item);
    @(negedge clk_i);
  endtask

  task automatic send_command(logic [olist_pkg::CMD_W-1:0] c,
                              logic signed [olist_pkg::VAL_W-1:0] v,
                              logic [olist_pkg::POS_W-1:0] p);
    olist_pkg::in_item_t item;
    item.cmd = c;
    item.value = v;
    item.position = p;
    push_command(item);
  endtask

  // Values lean on the extremes and on a narrow band, so that duplicates turn up.
  function automatic logic signed [olist_pkg::VAL_W-1:0] random_value();
    logic signed [olist_pkg::VAL_W-1:0] extremes[4];
    int roll;
    extremes = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1};
    roll = $urandom_range(7);
    if (roll == 0) return extremes[$urandom_range(3)];
    if (roll <= 3) return olist_pkg::VAL_W'($urandom_range(40) - 20);
    return $urandom;
  endfunction

  // Random command, biased to fill the list up to full and then drain it to empty.
  function automatic olist_pkg::in_item_t random_command();
    olist_pkg::in_item_t item;
    olist_pkg::cmd_e ins_cmds[3];
    olist_pkg::cmd_e del_cmds[3];
    int n;
    int roll;
    ins_cmds = '{olist_pkg::CMD_INS_FRONT, olist_pkg::CMD_INS_BACK, olist_pkg::CMD_INS_POS};
    del_cmds = '{olist_pkg::CMD_DEL_FRONT, olist_pkg::CMD_DEL_BACK, olist_pkg::CMD_DEL_POS};
    n = sb.entries.size();
    if (n == DEPTH && $urandom_range(3) == 0) filling = 1'b0;
    else if (n == 0 && $urandom_range(3) == 0) filling = 1'b1;

    item.value = random_value();
    item.position = olist_pkg::POS_W'($urandom_range(127));
    roll = $urandom_range(99);
    if (roll < 2) begin
      item.cmd = CMD_UNUSED;
    end else if (roll < (filling ? 70 : 27)) begin
      item.cmd = ins_cmds[$urandom_range(2)];
      if ($urandom_range(99) < 85) item.position = olist_pkg::POS_W'($urandom_range(n + 1, 1));
    end else if (roll < (filling ? 85 : 45)) begin
      item.cmd = olist_pkg::CMD_SEARCH;
      if (n > 0 && $urandom_range(99) < 60) item.value = sb.entries[$urandom_range(n - 1)];
    end else begin
      item.cmd = del_cmds[$urandom_range(2)];
      if (n > 0 && $urandom_range(99) < 85) item.position = olist_pkg::POS_W'($urandom_range(n, 1));
    end
    return item;
  endfunction

  // Main sequence.
  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    send_idle_pct = 9;
    recv_stall_pct = 57;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: the empty list, range errors, extremes, hits, misses and the unused code.
    send_command(olist_pkg::CMD_SEARCH, 32'sd5, 7'd1);
    send_command(olist_pkg::CMD_DEL_FRONT, 32'sd0, 7'd1);
    send_command(olist_pkg::CMD_DEL_BACK, 32'sd0, 7'd1);
    send_command(olist_pkg::CMD_DEL_POS, 32'sd0, 7'd1);
    send_command(olist_pkg::CMD_INS_POS, 32'sd3, 7'd0);
    send_command(olist_pkg::CMD_INS_POS, 32'sd3, 7'd2);
    send_command(olist_pkg::CMD_INS_POS, 32'sd7, 7'd1);
    send_command(olist_pkg::CMD_INS_FRONT, 32'sh7fff_ffff, 7'd0);
    send_command(olist_pkg::CMD_INS_BACK, 32'sh8000_0000, 7'd127);
    send_command(olist_pkg::CMD_INS_POS, -32'sd1, 7'd4);
    send_command(olist_pkg::CMD_INS_POS, 32'sd0, 7'd2);
    send_command(olist_pkg::CMD_INS_POS, 32'sd9, 7'd7);
    send_command(olist_pkg::CMD_SEARCH, 32'sd7, 7'd0);
    send_command(olist_pkg::CMD_SEARCH, 32'sd12345, 7'd0);
    send_command(olist_pkg::CMD_SEARCH, 32'sh8000_0000, 7'd0);
    send_command(olist_pkg::CMD_DEL_POS, 32'sd0, 7'd0);
    send_command(olist_pkg::CMD_DEL_POS, 32'sd0, 7'd6);
    send_command(olist_pkg::CMD_DEL_POS, 32'sd0, 7'd127);
    send_command(CMD_UNUSED, -32'sd1, 7'd127);
    send_command(olist_pkg::CMD_DEL_POS, 32'sd0, 7'd3);
    send_command(olist_pkg::CMD_INS_FRONT, 32'sd7, 7'd0);
    send_command(olist_pkg::CMD_SEARCH, 32'sd7, 7'd0);
    send_command(olist_pkg::CMD_DEL_BACK, 32'sd0, 7'd0);
    send_command(olist_pkg::CMD_DEL_FRONT, 32'sd0, 7'd0);

    // Random: sender idling light then heavy, then no idling on either side.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 9;
          recv_stall_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_stall_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      repeat (ITEMS_PER_PHASE) push_command(random_command());
    end
    in_valid_i <= 1'b0;

    // Let every outstanding result arrive, then watch for strays.
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ordered_list_engine_tb: clean");
    end else begin
      $display("ordered_list_engine_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/olist_pkg.sv
rtl/olist_scan.sv
rtl/ordered_list_engine.sv
rtl/olist_chk.sv
tb/ordered_list_engine_tb.sv
